// ===== rtl/core/ccur_pkg.sv =====
package ccur_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS = 45;

  localparam int ROW_W = 6;
  localparam int COL_W = 7;
  localparam int ADDR_W = $clog2(ROWS * COLUMNS);
  localparam int FILL_W = $clog2(COLUMNS);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [6:0] CELL_SPACE = 7'h20;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_PRINT,
    CMD_ECHO,
    CMD_READ,
    CMD_READ_NONE,
    CMD_CLEAR
  } cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FILL,
    BK_READ
  } bk_state_e;

  typedef struct packed {
    cmd_e             kind;
    logic [7:0]       ch;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic             echo_valid;
    logic [7:0]       echo_char;
    logic             row_redraw_valid;
    logic [ROW_W-1:0] row_to_redraw;
    logic             full_redraw;
    logic [6:0]       cell_value;
    logic [ROW_W-1:0] cursor_line;
    logic [COL_W-1:0] cursor_column;
  } res_t;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                input logic [ROW_W-1:0] vis);
    logic [ROW_W:0] sum;
    sum = {1'b0, top} + {1'b0, vis};
    if (sum >= (ROW_W + 1)'(ROWS)) begin
      sum = sum - (ROW_W + 1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

// ===== rtl/core/ccur_ram.sv =====
module ccur_ram #(
  parameter int Width = 7,
  parameter int Depth = 3600
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ccur_front.sv =====
module ccur_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            op_i,
  input  logic [7:0]            ch_i,
  input  logic [5:0]            read_row_i,
  input  logic [6:0]            read_col_i,
  input  logic                  queue_full_i,
  output logic                  push_o,
  output ccur_pkg::cmd_t        cmd_o
);
  import ccur_pkg::*;

  assign in_ready_o = !queue_full_i;
  assign push_o = in_valid_i && !queue_full_i;

  always_comb begin
    cmd_o.ch = ch_i;
    cmd_o.row = read_row_i;
    cmd_o.col = read_col_i;
    case (op_i)
      OP_PUT: begin
        if (ch_i == CH_NEWLINE) begin
          cmd_o.kind = CMD_NEWLINE;
        end else if (ch_i == CH_BACKSPACE) begin
          cmd_o.kind = CMD_BACKSPACE;
        end else if (ch_i inside {[8'h20:8'h7F]}) begin
          cmd_o.kind = CMD_PRINT;
        end else begin
          cmd_o.kind = CMD_ECHO;
        end
      end
      OP_READ: begin
        if (read_row_i < ROW_W'(ROWS) && read_col_i < COL_W'(COLUMNS)) begin
          cmd_o.kind = CMD_READ;
        end else begin
          cmd_o.kind = CMD_READ_NONE;
        end
      end
      OP_CLEAR: cmd_o.kind = CMD_CLEAR;
      default:  cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== rtl/core/ccur_fifo.sv =====
module ccur_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ccur_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ccur_pkg::cmd_t data_o
);
  import ccur_pkg::*;

  cmd_t              entries_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/ccur_back.sv =====
module ccur_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  ccur_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ccur_pkg::res_t res_o
);
  import ccur_pkg::*;

  bk_state_e         state_q, state_d;
  logic [ROW_W-1:0]  top_q, top_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROWS-1:0]   blank_q, blank_d;
  logic [FILL_W-1:0] fill_cnt_q, fill_cnt_d;
  logic [ROW_W-1:0]  fill_row_q, fill_row_d;
  logic              read_blank_q, read_blank_d;
  logic              out_valid_q;
  res_t              res_q, res;
  logic              res_load;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [6:0]        ram_wdata, ram_rdata;

  logic [ROW_W-1:0]  phys_cur, phys_rd;
  logic              start;
  logic              at_bottom;
  logic [ROW_W-1:0]  top_inc;
  logic [COL_W-1:0]  col_dec;

  assign phys_cur = phys_row(top_q, row_q);
  assign phys_rd = phys_row(top_q, cmd_i.row);
  assign start = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign at_bottom = (row_q == ROW_W'(ROWS - 1));
  assign top_inc = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + 1'b1;
  assign col_dec = col_q - 1'b1;

  always_comb begin
    state_d = state_q;
    top_d = top_q;
    row_d = row_q;
    col_d = col_q;
    blank_d = blank_q;
    fill_cnt_d = fill_cnt_q;
    fill_row_d = fill_row_q;
    read_blank_d = read_blank_q;
    cmd_pop_o = 1'b0;
    res_load = 1'b0;
    res = '0;
    ram_we = 1'b0;
    ram_waddr = cell_addr(phys_cur, col_q);
    ram_wdata = CELL_SPACE;
    ram_re = 1'b0;
    ram_raddr = cell_addr(phys_rd, cmd_i.col);

    case (state_q)
      BK_IDLE: begin
        if (start) begin
          case (cmd_i.kind)
            CMD_NEWLINE: begin
              ram_we = (col_q < COL_W'(COLUMNS)) && !blank_q[phys_cur];
              col_d = '0;
              if (at_bottom) begin
                blank_d[top_q] = 1'b1;
                top_d = top_inc;
              end else begin
                row_d = row_q + 1'b1;
              end
              res.echo_valid = 1'b1;
              res.echo_char = cmd_i.ch;
              res.full_redraw = 1'b1;
              cmd_pop_o = 1'b1;
              res_load = 1'b1;
            end
            CMD_BACKSPACE: begin
              if (col_q != '0) begin
                col_d = col_dec;
                ram_waddr = cell_addr(phys_cur, col_dec);
                ram_we = !blank_q[phys_cur];
                res.row_redraw_valid = 1'b1;
                res.row_to_redraw = row_q;
              end
              res.echo_valid = 1'b1;
              res.echo_char = cmd_i.ch;
              cmd_pop_o = 1'b1;
              res_load = 1'b1;
            end
            CMD_PRINT: begin
              if (col_q >= COL_W'(COLUMNS)) begin
                col_d = '0;
                if (at_bottom) begin
                  blank_d[top_q] = 1'b1;
                  top_d = top_inc;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end else if (blank_q[phys_cur]) begin
                state_d = BK_FILL;
                fill_cnt_d = '0;
                fill_row_d = phys_cur;
              end else begin
                ram_we = 1'b1;
                ram_wdata = cmd_i.ch[6:0];
                col_d = col_q + 1'b1;
                res.echo_valid = 1'b1;
                res.echo_char = cmd_i.ch;
                res.row_redraw_valid = 1'b1;
                res.row_to_redraw = row_q;
                cmd_pop_o = 1'b1;
                res_load = 1'b1;
              end
            end
            CMD_ECHO: begin
              res.echo_valid = 1'b1;
              res.echo_char = cmd_i.ch;
              cmd_pop_o = 1'b1;
              res_load = 1'b1;
            end
            CMD_READ: begin
              ram_re = 1'b1;
              read_blank_d = blank_q[phys_rd];
              cmd_pop_o = 1'b1;
              state_d = BK_READ;
            end
            CMD_CLEAR: begin
              blank_d = '1;
              top_d = '0;
              row_d = '0;
              col_d = '0;
              res.full_redraw = 1'b1;
              cmd_pop_o = 1'b1;
              res_load = 1'b1;
            end
            default: begin
              cmd_pop_o = 1'b1;
              res_load = 1'b1;
            end
          endcase
        end
      end
      BK_FILL: begin
        ram_we = 1'b1;
        ram_waddr = cell_addr(fill_row_q, COL_W'(fill_cnt_q));
        if (fill_cnt_q == FILL_W'(COLUMNS - 1)) begin
          blank_d[fill_row_q] = 1'b0;
          state_d = BK_IDLE;
        end else begin
          fill_cnt_d = fill_cnt_q + 1'b1;
        end
      end
      BK_READ: begin
        res.cell_value = read_blank_q ? CELL_SPACE : ram_rdata;
        res_load = 1'b1;
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    res.cursor_line = row_d;
    res.cursor_column = col_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      top_q <= '0;
      row_q <= '0;
      col_q <= '0;
      blank_q <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q <= top_d;
      row_q <= row_d;
      col_q <= col_d;
      blank_q <= blank_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fill_cnt_q <= fill_cnt_d;
    fill_row_q <= fill_row_d;
    read_blank_q <= read_blank_d;
    if (res_load) begin
      res_q <= res;
    end
  end

  ccur_ram #(
    .Width(7),
    .Depth(ROWS * COLUMNS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign res_o = res_q;

endmodule

// ===== rtl/core/text_console_cursor_engine.sv =====
// Channel  Handshake                   Word
// in       in_valid_i / in_ready_o     op_i, ch_i, read_row_i, read_col_i
// out      out_valid_o / out_ready_i   echo, redraw, cell and cursor fields
//
// A word accepted at the input is queued, then loaded into the output register once that register is free.
// A cell read also passes through the BK_READ state because the character memory read is registered.
// A printable character at a full row first wraps the line without being popped, then is handled again.
// Writing into a row that is still blank stalls in BK_FILL, which writes spaces to all 80 cells of the row.
// Reset needs no clearing pass: per-row blank flags make every row read as space.
// The input side keeps accepting words until the two-entry command queue is full.
module text_console_cursor_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] ch_i,
  input  logic [5:0] read_row_i,
  input  logic [6:0] read_col_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       echo_valid_o,
  output logic [7:0] echo_char_o,
  output logic       row_redraw_valid_o,
  output logic [5:0] row_to_redraw_o,
  output logic       full_redraw_o,
  output logic [6:0] cell_value_o,
  output logic [5:0] cursor_line_o,
  output logic [6:0] cursor_column_o
);
  import ccur_pkg::*;

  logic queue_full, push, cmd_valid, cmd_pop;
  cmd_t cmd_in, cmd_out;
  res_t res;

  ccur_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .ch_i        (ch_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .queue_full_i(queue_full),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  ccur_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .full_o (queue_full),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .data_o (cmd_out)
  );

  ccur_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res)
  );

  assign echo_valid_o = res.echo_valid;
  assign echo_char_o = res.echo_char;
  assign row_redraw_valid_o = res.row_redraw_valid;
  assign row_to_redraw_o = res.row_to_redraw;
  assign full_redraw_o = res.full_redraw;
  assign cell_value_o = res.cell_value;
  assign cursor_line_o = res.cursor_line;
  assign cursor_column_o = res.cursor_column;

endmodule
